FILE: design/isr_pkg.sv
// Shared types and constants for the integer square root block.
// No dependencies; imported by the controller, datapath and top level.
package isr_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int ROOT_WIDTH  = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } isr_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } isr_cmd_t;

    typedef struct packed {
        logic last;
    } isr_status_t;

endpackage

FILE: design/isr_ctrl.sv
// Sequencer for the integer square root: handshakes and iteration control.
// Depends on isr_pkg; drives the datapath through isr_cmd_t.
module isr_ctrl
    import isr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  isr_status_t status,
    output isr_cmd_t    cmd
);

    isr_state_t state_reg;
    isr_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    if (out_free)
                    begin
                        cmd.publish = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || m_tready))
        else $error("result published over a beat not yet taken");

    a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_RUN))
        else $error("accepted beat did not start iteration");

    a_wait_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> m_tvalid)
        else $error("waiting on an empty output register");

endmodule

FILE: design/isr_datapath.sv
// Digit-by-digit square root datapath: remainder, partial root, bit mask, output.
// Depends on isr_pkg; commanded by isr_ctrl.
module isr_datapath
    import isr_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  isr_cmd_t                cmd,
    input  logic [VALUE_WIDTH-1:0]  value,
    output isr_status_t             status,
    output logic [ROOT_WIDTH-1:0]   root
);

    localparam int RootBits = (OPERAND_WIDTH + 1) / 2;
    localparam int AccWidth = 2 * RootBits;
    localparam logic [AccWidth-1:0] BitInit = AccWidth'(1) << (AccWidth - 2);
    localparam logic [AccWidth-1:0] OperandMask =
        {AccWidth{1'b1}} >> (AccWidth - OPERAND_WIDTH);

    logic [AccWidth-1:0]   rem_reg;
    logic [AccWidth-1:0]   res_reg;
    logic [AccWidth-1:0]   bit_reg;
    logic [ROOT_WIDTH-1:0] root_reg;

    logic [AccWidth-1:0] trial;
    logic                fits;
    logic [AccWidth-1:0] rem_step;
    logic [AccWidth-1:0] res_step;

    assign trial    = res_reg + bit_reg;
    assign fits     = rem_reg >= trial;
    assign rem_step = fits ? rem_reg - trial : rem_reg;
    assign res_step = fits ? (res_reg >> 1) + bit_reg : res_reg >> 1;

    assign status.last = bit_reg[0];
    assign root        = root_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= AccWidth'(value) & OperandMask;
            res_reg <= '0;
            bit_reg <= BitInit;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_step;
            res_reg <= res_step;
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.publish)
        begin
            if (cmd.step)
                root_reg <= ROOT_WIDTH'(res_step);
            else
                root_reg <= ROOT_WIDTH'(res_reg);
        end
    end

    a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> $onehot(bit_reg))
        else $error("iteration without a single trial bit");

    a_load_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (bit_reg == BitInit && res_reg == '0))
        else $error("load did not set up the first iteration");

    a_no_load_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.step))
        else $error("load and iteration in the same cycle");

endmodule

FILE: design/integer_square_root.sv
// Integer square root: accepts one operand beat and returns floor(sqrt(value)).
// The operand loads at the accepting edge, then the shared subtract-and-compare stage in
// the datapath produces one root bit per cycle until the result is written to the output
// register. One operand is worked at a time and the input is ready again only in the
// cycle after the result is published, so a new operand is not taken before the last
// one is done. A new beat is taken as soon as the previous result sits in the output
// register, even if it has not been taken yet; a finished root that finds that register
// still full waits until it drains. Only the low OPERAND_WIDTH bits of value are used,
// and root carries the low 16 bits of the result.
// Depends on isr_pkg, isr_ctrl and isr_datapath.
module integer_square_root
    import isr_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_WIDTH-1:0] s_tdata,   // [31:0] value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [ROOT_WIDTH-1:0]  m_tdata    // [15:0] root
);

    isr_cmd_t    cmd;
    isr_status_t status;

    isr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    isr_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .value  (s_tdata),
        .status (status),
        .root   (m_tdata)
    );

endmodule
